FILE: hw/rtl/sdf_pkg.sv
// Shared widths, types, constants and arithmetic helpers of the scene distance core.
package sdf_pkg;

    // Default position of the binary point in the coordinate and distance fields.
    localparam int FracBitsDef = 16;

    // Field and datapath widths.
    localparam int InW = 20;           // coordinate and distance fields
    localparam int CW  = 26;           // primitive-local coordinates
    localparam int AW  = CW + 2;       // sum of three absolute values
    localparam int SW  = 2 * CW;       // sum of squares fed to a root
    localparam int RW  = SW / 2;       // root result
    localparam int DW  = 32;           // signed distances
    localparam int PW  = 56;           // products with a constant

    // Root pipeline shape: one result bit per step, two steps per stage.
    localparam int RootSteps    = SW / 2;
    localparam int RootPerStage = 2;
    localparam int RootStages   = RootSteps / RootPerStage;

    // Scene constants in units of 1e-9.
    localparam longint NRing  = 64'sd300000000;
    localparam longint NRingS = 64'sd259807621;
    localparam longint NRingH = 64'sd150000000;
    localparam longint NSphR  = 64'sd100000000;
    localparam longint NCubH  = 64'sd75000000;
    localparam longint NConeA = 64'sd894427191;
    localparam longint NConeB = 64'sd447213595;
    localparam longint NConeO = 64'sd89442719;
    localparam longint NCylR  = 64'sd100000000;
    localparam longint NCylH  = 64'sd100000000;
    localparam longint NTorR  = 64'sd80000000;
    localparam longint NTorT  = 64'sd40000000;
    localparam longint NOctS  = 64'sd150000000;
    localparam longint NOctK  = 64'sd577350270;
    localparam longint NCapH  = 64'sd75000000;
    localparam longint NCapR  = 64'sd75000000;

    // Saturation limits of the distance field.
    localparam logic signed [DW-1:0] OutMax = DW'((64'sd1 <<< (InW - 1)) - 64'sd1);
    localparam logic signed [DW-1:0] OutMin = DW'(-(64'sd1 <<< (InW - 1)));

    // Sums of squares handed from the front end to the six first-pass roots.
    typedef struct packed {
        logic [SW-1:0] sph_s;
        logic [SW-1:0] cub_s;
        logic [SW-1:0] cone_s;
        logic [SW-1:0] cyl_s;
        logic [SW-1:0] tor_s;
        logic [SW-1:0] cap_s;
    } t_roots_in;

    // Terms that wait beside the roots until the roots are done.
    typedef struct packed {
        logic signed [DW-1:0] cub_in;
        logic signed [DW-1:0] cone_zb;
        logic signed [DW-1:0] cone_nz;
        logic signed [DW-1:0] cyl_zt;
        logic [SW-1:0]        tor_z2;
        logic signed [DW-1:0] octa;
    } t_side;

    // Partial remainder and partial root of the bit-serial square root.
    typedef struct packed {
        logic [SW-1:0] rem;
        logic [SW:0]   res;
    } t_root;

    // Round-half-up fixed-point value of a constant given in units of 1e-9.
    function automatic logic signed [DW-1:0] fix_c(input longint n, input int frac);
        longint v;
        v = ((n <<< frac) + 64'sd500000000) / 64'sd1000000000;
        return DW'(v);
    endfunction

    // Product with a constant, rounded back to the value scale.
    function automatic logic signed [DW-1:0] round_shift(input logic signed [PW-1:0] p,
                                                         input int frac);
        logic signed [PW-1:0] t;
        t = (p + (PW'(64'sd1) <<< (frac - 1))) >>> frac;
        return DW'(t);
    endfunction

    function automatic logic signed [DW-1:0] ext_u(input logic [RW-1:0] v);
        return $signed(DW'(v));
    endfunction

    function automatic logic signed [DW-1:0] abs_d(input logic signed [DW-1:0] v);
        return (v < 0) ? -v : v;
    endfunction

    function automatic logic signed [DW-1:0] max_d(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function automatic logic signed [DW-1:0] min_d(input logic signed [DW-1:0] a,
                                                   input logic signed [DW-1:0] b);
        return (a < b) ? a : b;
    endfunction

    function automatic logic [SW-1:0] sq(input logic signed [CW-1:0] v);
        logic signed [SW-1:0] p;
        p = v * v;
        return p;
    endfunction

    // One step of the restoring square root; step k tries bit 2^(SW-2-2k).
    function automatic t_root root_step(input t_root a, input int k);
        t_root       r;
        logic [SW:0] bitv;
        logic [SW:0] trial;
        bitv  = {{SW{1'b0}}, 1'b1} << (SW - 2 - 2 * k);
        trial = a.res + bitv;
        if ({1'b0, a.rem} >= trial) begin
            r.rem = a.rem - trial[SW-1:0];
            r.res = (a.res >> 1) + bitv;
        end else begin
            r.rem = a.rem;
            r.res = a.res >> 1;
        end
        return r;
    endfunction

endpackage

FILE: hw/rtl/sdf_isqrt.sv
// Pipelined integer square root, two result bits per register stage.
module sdf_isqrt (
    input  logic                   i_clk,
    input  logic [sdf_pkg::SW-1:0] i_sum,
    output logic [sdf_pkg::RW-1:0] o_root
);
    import sdf_pkg::*;

    t_root r_stage  [RootStages];
    t_root n_stage  [RootStages];
    t_root stage_in [RootStages];

    for (genvar s = 0; s < RootStages; s++) begin : g_stage
        // The first stage starts from the raw sum, later ones from the previous stage.
        if (s == 0) begin : g_first
            assign stage_in[s] = '{rem: i_sum, res: '0};
        end else begin : g_link
            assign stage_in[s] = r_stage[s-1];
        end

        // Two dependent compare-and-subtract steps per stage.
        always_comb begin
            t_root t;
            t = stage_in[s];
            for (int j = 0; j < RootPerStage; j++) begin
                t = root_step(t, s * RootPerStage + j);
            end
            n_stage[s] = t;
        end

        always_ff @(posedge i_clk) begin
            r_stage[s] <= n_stage[s];
        end
    end

    assign o_root = r_stage[RootStages-1].res[RW-1:0];

endmodule

FILE: hw/rtl/sdf_delay.sv
// Fixed-length delay line that carries a payload and its valid bit.
module sdf_delay #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_data [DEPTH];
    logic [DEPTH-1:0] r_valid;

    // Valid taps are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid[0] <= i_valid;
            for (int k = 1; k < DEPTH; k++) begin
                r_valid[k] <= r_valid[k-1];
            end
        end
    end

    // Payload taps shift every cycle.
    always_ff @(posedge i_clk) begin
        r_data[0] <= i_data;
        for (int k = 1; k < DEPTH; k++) begin
            r_data[k] <= r_data[k-1];
        end
    end

    assign o_valid = r_valid[DEPTH-1];
    assign o_data  = r_data[DEPTH-1];

    // A valid beat at the end was injected at the input and has passed all DEPTH taps.
    a_valid_age: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(i_valid, DEPTH))
        else $error("delay line produced a beat that was never injected");

endmodule

FILE: hw/rtl/sdf_front.sv
// Front end: local coordinates, squares and sums of squares for every primitive.
module sdf_front #(
    parameter int FRAC_BITS = sdf_pkg::FracBitsDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic signed [sdf_pkg::InW-1:0] i_px,
    input  logic signed [sdf_pkg::InW-1:0] i_py,
    input  logic signed [sdf_pkg::InW-1:0] i_pz,
    output logic                           o_valid,
    output sdf_pkg::t_roots_in             o_roots,
    output sdf_pkg::t_side                 o_side
);
    import sdf_pkg::*;

    localparam logic signed [DW-1:0] KRing  = fix_c(NRing, FRAC_BITS);
    localparam logic signed [DW-1:0] KRingS = fix_c(NRingS, FRAC_BITS);
    localparam logic signed [DW-1:0] KRingH = fix_c(NRingH, FRAC_BITS);
    localparam logic signed [DW-1:0] KCubH  = fix_c(NCubH, FRAC_BITS);
    localparam logic signed [DW-1:0] KConeB = fix_c(NConeB, FRAC_BITS);
    localparam logic signed [DW-1:0] KConeO = fix_c(NConeO, FRAC_BITS);
    localparam logic signed [DW-1:0] KCylH  = fix_c(NCylH, FRAC_BITS);
    localparam logic signed [DW-1:0] KOctS  = fix_c(NOctS, FRAC_BITS);
    localparam logic signed [DW-1:0] KOctK  = fix_c(NOctK, FRAC_BITS);
    localparam logic signed [DW-1:0] KCapH  = fix_c(NCapH, FRAC_BITS);

    // Stage 1: input registers.
    logic                  r_s1_valid;
    logic signed [InW-1:0] r_s1_x, r_s1_y, r_s1_z;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_x <= i_px;
        r_s1_y <= i_py;
        r_s1_z <= i_pz;
    end

    // Stage 2: offsets to each primitive center, clamps and absolute values.
    logic                 r_s2_valid;
    logic signed [CW-1:0] r_s2_x, r_s2_y, r_s2_z;
    logic signed [CW-1:0] r_s2_cbx, r_s2_cby, r_s2_cbz;
    logic signed [CW-1:0] r_s2_ax, r_s2_cny, r_s2_cyy, r_s2_ty, r_s2_bx, r_s2_cpw;
    logic signed [AW-1:0] r_s2_oc;
    logic signed [DW-1:0] r_s2_cbin, r_s2_cyzt;
    logic signed [CW-1:0] n_s2_cbx, n_s2_cby, n_s2_cbz, n_s2_cpw;
    logic signed [AW-1:0] n_s2_oc;
    logic signed [DW-1:0] n_s2_cbin, n_s2_cyzt;
    logic signed [DW-1:0] x_d, y_d, z_d;

    assign x_d = DW'(r_s1_x);
    assign y_d = DW'(r_s1_y);
    assign z_d = DW'(r_s1_z);

    always_comb begin
        logic signed [DW-1:0] dx, dy, dz;
        dx = abs_d(x_d) - KCubH;
        dy = abs_d(y_d - KRing) - KCubH;
        dz = abs_d(z_d) - KCubH;
        n_s2_cbx  = CW'(max_d(dx, '0));
        n_s2_cby  = CW'(max_d(dy, '0));
        n_s2_cbz  = CW'(max_d(dz, '0));
        n_s2_cbin = min_d(max_d(dx, max_d(dy, dz)), '0);
        n_s2_oc   = AW'(abs_d(x_d + KRingS) + abs_d(y_d + KRingH) + abs_d(z_d) - KOctS);
        n_s2_cpw  = CW'(z_d - min_d(max_d(z_d, -KCapH), KCapH));
        n_s2_cyzt = max_d(z_d - KCylH, -z_d - KCylH);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s2_x    <= CW'(x_d);
        r_s2_y    <= CW'(y_d);
        r_s2_z    <= CW'(z_d);
        r_s2_cbx  <= n_s2_cbx;
        r_s2_cby  <= n_s2_cby;
        r_s2_cbz  <= n_s2_cbz;
        r_s2_cbin <= n_s2_cbin;
        r_s2_ax   <= CW'(x_d - KRingS);
        r_s2_cny  <= CW'(y_d - KRingH);
        r_s2_cyy  <= CW'(y_d + KRingH);
        r_s2_ty   <= CW'(y_d + KRing);
        r_s2_bx   <= CW'(x_d + KRingS);
        r_s2_cpw  <= n_s2_cpw;
        r_s2_oc   <= n_s2_oc;
        r_s2_cyzt <= n_s2_cyzt;
    end

    // Stage 3: squares and the two products with constants.
    logic                 r_s3_valid;
    logic [SW-1:0]        r_s3_x2, r_s3_y2, r_s3_z2, r_s3_cbx2, r_s3_cby2, r_s3_cbz2;
    logic [SW-1:0]        r_s3_ax2, r_s3_cny2, r_s3_cyy2, r_s3_ty2, r_s3_bx2, r_s3_cpw2;
    logic signed [PW-1:0] r_s3_ocp, r_s3_zbp;
    logic signed [PW-1:0] n_s3_ocp, n_s3_zbp;
    logic signed [DW-1:0] r_s3_cbin, r_s3_cyzt, r_s3_nz;

    assign n_s3_ocp = r_s2_oc * KOctK;
    assign n_s3_zbp = r_s2_z * KConeB;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s3_valid <= 1'b0;
        end else begin
            r_s3_valid <= r_s2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s3_x2   <= sq(r_s2_x);
        r_s3_y2   <= sq(r_s2_y);
        r_s3_z2   <= sq(r_s2_z);
        r_s3_cbx2 <= sq(r_s2_cbx);
        r_s3_cby2 <= sq(r_s2_cby);
        r_s3_cbz2 <= sq(r_s2_cbz);
        r_s3_ax2  <= sq(r_s2_ax);
        r_s3_cny2 <= sq(r_s2_cny);
        r_s3_cyy2 <= sq(r_s2_cyy);
        r_s3_ty2  <= sq(r_s2_ty);
        r_s3_bx2  <= sq(r_s2_bx);
        r_s3_cpw2 <= sq(r_s2_cpw);
        r_s3_ocp  <= n_s3_ocp;
        r_s3_zbp  <= n_s3_zbp;
        r_s3_cbin <= r_s2_cbin;
        r_s3_cyzt <= r_s2_cyzt;
        r_s3_nz   <= -DW'(r_s2_z);
    end

    // Stage 4: sums of squares for the roots, rounded constant products.
    logic      r_s4_valid;
    t_roots_in r_roots;
    t_side     r_side;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s4_valid <= 1'b0;
        end else begin
            r_s4_valid <= r_s3_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_roots.sph_s  <= r_s3_x2 + r_s3_y2 + r_s3_z2;
        r_roots.cub_s  <= r_s3_cbx2 + r_s3_cby2 + r_s3_cbz2;
        r_roots.cone_s <= r_s3_ax2 + r_s3_cny2;
        r_roots.cyl_s  <= r_s3_ax2 + r_s3_cyy2;
        r_roots.tor_s  <= r_s3_x2 + r_s3_ty2;
        r_roots.cap_s  <= r_s3_bx2 + r_s3_cny2 + r_s3_cpw2;
        r_side.cub_in  <= r_s3_cbin;
        r_side.cone_zb <= round_shift(r_s3_zbp, FRAC_BITS) - KConeO;
        r_side.cone_nz <= r_s3_nz;
        r_side.cyl_zt  <= r_s3_cyzt;
        r_side.tor_z2  <= r_s3_z2;
        r_side.octa    <= round_shift(r_s3_ocp, FRAC_BITS);
    end

    assign o_valid = r_s4_valid;
    assign o_roots = r_roots;
    assign o_side  = r_side;

    // The sphere sum contains the z square that the torus reuses.
    a_sum_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_roots.sph_s >= o_side.tor_z2))
        else $error("sphere sum of squares smaller than its own z term");

endmodule

FILE: hw/rtl/sdf_scene_distance_core.sv
// Top level of the scene distance core: roots, primitive distances and the union.
//
// A point (i_px, i_py, i_pz) is taken in at a rising edge where start is high and
// busy is low. busy is held low: the datapath is a fixed pipeline that takes one
// point beat in every cycle, back to back, with no gaps required.
// Each point gives exactly one distance beat. o_valid is high for one cycle per
// beat, and o_distance holds the distance in that cycle.
// Beats leave in the order the points came in.
// The latency is set by two chained square roots (the torus takes the root of a
// value that itself holds a root); each root is a 13-stage unit that resolves two
// result bits per stage. Four front-end stages, three stages between the roots and
// one output stage make up the rest. Throughput is one point per cycle.
// Reset (i_rst_n low at a clock edge) clears every valid bit, so points in flight
// are dropped and o_valid is low after reset; the datapath needs no clearing.
// The receiver cannot stall the output: a beat must be taken in its one cycle.
// The distance saturates at the ends of the 20-bit signed range.
module sdf_scene_distance_core #(
    parameter int FRAC_BITS = sdf_pkg::FracBitsDef
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic signed [sdf_pkg::InW-1:0] i_px,
    input  logic signed [sdf_pkg::InW-1:0] i_py,
    input  logic signed [sdf_pkg::InW-1:0] i_pz,
    output logic                           o_valid,
    output logic signed [sdf_pkg::InW-1:0] o_distance
);
    import sdf_pkg::*;

    localparam int Latency = 4 + RootStages + 3 + RootStages + 1;

    localparam logic signed [DW-1:0] KSphR  = fix_c(NSphR, FRAC_BITS);
    localparam logic signed [DW-1:0] KConeA = fix_c(NConeA, FRAC_BITS);
    localparam logic signed [DW-1:0] KCylR  = fix_c(NCylR, FRAC_BITS);
    localparam logic signed [DW-1:0] KTorR  = fix_c(NTorR, FRAC_BITS);
    localparam logic signed [DW-1:0] KTorT  = fix_c(NTorT, FRAC_BITS);
    localparam logic signed [DW-1:0] KCapR  = fix_c(NCapR, FRAC_BITS);

    assign busy = 1'b0;

    // Front end.
    logic      f_valid;
    t_roots_in f_roots;
    t_side     f_side;

    sdf_front #(
        .FRAC_BITS (FRAC_BITS)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start & ~busy),
        .i_px    (i_px),
        .i_py    (i_py),
        .i_pz    (i_pz),
        .o_valid (f_valid),
        .o_roots (f_roots),
        .o_side  (f_side)
    );

    // First pass of roots, one unit per primitive that needs one.
    logic [RW-1:0] q_sph, q_cub, q_cone, q_cyl, q_tor, q_cap;

    sdf_isqrt u_root_sph  (.i_clk(i_clk), .i_sum(f_roots.sph_s),  .o_root(q_sph));
    sdf_isqrt u_root_cub  (.i_clk(i_clk), .i_sum(f_roots.cub_s),  .o_root(q_cub));
    sdf_isqrt u_root_cone (.i_clk(i_clk), .i_sum(f_roots.cone_s), .o_root(q_cone));
    sdf_isqrt u_root_cyl  (.i_clk(i_clk), .i_sum(f_roots.cyl_s),  .o_root(q_cyl));
    sdf_isqrt u_root_tor  (.i_clk(i_clk), .i_sum(f_roots.tor_s),  .o_root(q_tor));
    sdf_isqrt u_root_cap  (.i_clk(i_clk), .i_sum(f_roots.cap_s),  .o_root(q_cap));

    // Side terms and valid wait beside the roots.
    logic  d_valid;
    t_side d_side;

    sdf_delay #(
        .WIDTH ($bits(t_side)),
        .DEPTH (RootStages)
    ) u_side_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (f_valid),
        .i_data  (f_side),
        .o_valid (d_valid),
        .o_data  (d_side)
    );

    // Stage C1: primitive distances from the first roots, cone slope product.
    logic                 r_c1_valid;
    logic signed [DW-1:0] r_c1_sph, r_c1_cub, r_c1_cone_m, r_c1_cone_zb;
    logic signed [DW-1:0] r_c1_cyl, r_c1_cap, r_c1_oct;
    logic signed [PW-1:0] r_c1_qa;
    logic signed [CW:0]   r_c1_t;
    logic [SW-1:0]        r_c1_z2;
    logic signed [PW-1:0] n_c1_qa;
    logic signed [RW:0]   q_cone_s;

    assign q_cone_s = $signed({1'b0, q_cone});
    assign n_c1_qa  = q_cone_s * KConeA;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c1_valid <= 1'b0;
        end else begin
            r_c1_valid <= d_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c1_sph     <= ext_u(q_sph) - KSphR;
        r_c1_cub     <= ext_u(q_cub) + d_side.cub_in;
        r_c1_qa      <= n_c1_qa;
        r_c1_cone_m  <= max_d(-ext_u(q_cone), d_side.cone_nz);
        r_c1_cone_zb <= d_side.cone_zb;
        r_c1_cyl     <= max_d(ext_u(q_cyl) - KCylR, d_side.cyl_zt);
        r_c1_t       <= (CW+1)'(KTorR - ext_u(q_tor));
        r_c1_z2      <= d_side.tor_z2;
        r_c1_cap     <= ext_u(q_cap) - KCapR;
        r_c1_oct     <= d_side.octa;
    end

    // Stage C2: cone side plane, torus tube square, first union level.
    logic                   r_c2_valid;
    logic signed [DW-1:0]   r_c2_cone, r_c2_ma, r_c2_mb, r_c2_oct;
    logic [SW-1:0]          r_c2_t2, r_c2_z2;
    logic signed [2*CW+1:0] n_c2_t2;

    assign n_c2_t2 = r_c1_t * r_c1_t;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c2_valid <= 1'b0;
        end else begin
            r_c2_valid <= r_c1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c2_cone <= max_d(r_c1_cone_m, round_shift(r_c1_qa, FRAC_BITS) + r_c1_cone_zb);
        r_c2_t2   <= n_c2_t2[SW-1:0];
        r_c2_z2   <= r_c1_z2;
        r_c2_ma   <= min_d(r_c1_sph, r_c1_cub);
        r_c2_mb   <= min_d(r_c1_cyl, r_c1_cap);
        r_c2_oct  <= r_c1_oct;
    end

    // Stage C3: torus root input, second union level.
    logic                 r_c3_valid;
    logic [SW-1:0]        r_c3_s2;
    logic signed [DW-1:0] r_c3_mc, r_c3_md;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_c3_valid <= 1'b0;
        end else begin
            r_c3_valid <= r_c2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_c3_s2 <= r_c2_t2 + r_c2_z2;
        r_c3_mc <= min_d(r_c2_ma, r_c2_mb);
        r_c3_md <= min_d(r_c2_cone, r_c2_oct);
    end

    // Second torus root, with the partial union waiting beside it.
    logic [RW-1:0]   q_tor2;
    logic            m_valid;
    logic [2*DW-1:0] m_pair;

    sdf_isqrt u_root_tor2 (.i_clk(i_clk), .i_sum(r_c3_s2), .o_root(q_tor2));

    sdf_delay #(
        .WIDTH (2 * DW),
        .DEPTH (RootStages)
    ) u_min_dly (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (r_c3_valid),
        .i_data  ({r_c3_mc, r_c3_md}),
        .o_valid (m_valid),
        .o_data  (m_pair)
    );

    // Output stage: torus distance, final union and saturation.
    logic                  r_valid;
    logic signed [InW-1:0] r_dist;
    logic signed [DW-1:0]  n_min;
    logic signed [InW-1:0] n_dist;

    always_comb begin
        logic signed [DW-1:0] tor;
        tor   = ext_u(q_tor2) - KTorT;
        n_min = min_d(min_d($signed(m_pair[2*DW-1:DW]), $signed(m_pair[DW-1:0])), tor);
        if (n_min > OutMax) begin
            n_dist = OutMax[InW-1:0];
        end else if (n_min < OutMin) begin
            n_dist = OutMin[InW-1:0];
        end else begin
            n_dist = n_min[InW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= m_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_dist <= n_dist;
    end

    assign o_valid    = r_valid;
    assign o_distance = r_dist;

    // Every result beat belongs to a point accepted a full pipeline length earlier.
    a_beat_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, Latency))
        else $error("result beat without a matching accepted point");

    // Reset empties the pipeline.
    a_reset_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result beat right after reset");

endmodule
